>>> hw/rtl/tgb_pkg.sv
// ----------------------------------------------------------------------------
// tgb_pkg
// Shared constants, types and controller/datapath signal groups for the text
// grid buffer.
// ----------------------------------------------------------------------------
package tgb_pkg;

    // Default grid size.
    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 32;

    // Fixed field widths.
    localparam int CH_W  = 8;   // character
    localparam int POS_W = 8;   // column and row
    localparam int OFS_W = 9;   // signed scroll offsets
    localparam int SP_W  = 10;  // signed source position during a scroll

    // Operation codes carried with each input word.
    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_SCROLL = 2'd3
    } t_mode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;        // capture the accepted input word
        logic exec;         // decode and start the latched operation
        logic clear_step;   // write one cell of a clear sweep
        logic scroll_step;  // move one cell of a scroll sweep
        logic drain;        // commit the last pending scroll write
        logic load;         // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_mode mode;        // latched operation
        logic  last;        // sweep is at its final cell
        logic  out_free;    // result register can take a new word
    } t_dp_sts;

endpackage

>>> hw/rtl/tgb_ram.sv
// ----------------------------------------------------------------------------
// tgb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its value while no read is enabled.
// ----------------------------------------------------------------------------
module tgb_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/tgb_ctrl.sv
// ----------------------------------------------------------------------------
// tgb_ctrl
// Controller state machine: accepts one word at a time, sequences the clear
// and scroll sweeps, and hands the result to the output register.
// ----------------------------------------------------------------------------
module tgb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tgb_pkg::t_dp_sts i_sts,
    output tgb_pkg::t_dp_cmd o_cmd
);

    import tgb_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_CLEAR  = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_sts.mode)
                    MODE_CLEAR:  n_state = ST_CLEAR;
                    MODE_SCROLL: n_state = ST_SCROLL;
                    default:     n_state = ST_FINISH;
                endcase
            end
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_SCROLL: begin
                o_cmd.scroll_step = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                o_cmd.drain = 1'b1;
                n_state     = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

>>> hw/rtl/tgb_dp.sv
// ----------------------------------------------------------------------------
// tgb_dp
// Datapath: input latch, fill character register, cell RAM, sweep counters
// for clear and scroll, and the result register.
// ----------------------------------------------------------------------------
module tgb_dp #(
    parameter int COLS = tgb_pkg::COLS_DEF,
    parameter int ROWS = tgb_pkg::ROWS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tgb_pkg::t_dp_cmd                   i_cmd,
    output tgb_pkg::t_dp_sts                   o_sts,
    input  logic [1:0]                         i_mode,
    input  logic [tgb_pkg::POS_W-1:0]          i_col,
    input  logic [tgb_pkg::POS_W-1:0]          i_row,
    input  logic [tgb_pkg::CH_W-1:0]           i_char_in,
    input  logic signed [tgb_pkg::OFS_W-1:0]   i_scroll_rows,
    input  logic signed [tgb_pkg::OFS_W-1:0]   i_scroll_cols,
    input  logic                               i_cfg_we,
    input  logic [tgb_pkg::CH_W-1:0]           i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tgb_pkg::CH_W-1:0]           o_read_char,
    output logic                               o_in_range
);

    import tgb_pkg::*;

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int DW    = $clog2(COLS) + 10;

    // Latched input word.
    t_mode                   r_mode;
    logic [POS_W-1:0]        r_col;
    logic [POS_W-1:0]        r_row;
    logic [CH_W-1:0]         r_char;
    logic signed [OFS_W-1:0] r_srows;
    logic signed [OFS_W-1:0] r_scols;

    logic [CH_W-1:0]         r_clear_char;

    // Sweep state.
    logic [AW-1:0]           r_addr;
    logic [CW-1:0]           r_c;
    logic signed [SP_W-1:0]  r_sc;
    logic signed [SP_W-1:0]  r_sr;
    logic                    r_desc;
    logic signed [DW-1:0]    r_dofs;
    logic                    r_in_range;
    logic                    r_pend_valid;
    logic [AW-1:0]           r_pend_addr;
    logic                    r_pend_ram;

    logic                    r_out_valid;
    logic [CH_W-1:0]         r_read_char;
    logic                    r_out_range;

    logic                    w_in_range;
    logic [AW-1:0]           w_cell_addr;
    logic signed [DW-1:0]    w_dofs;
    logic                    w_desc;
    logic                    w_src_ok;
    logic [DW-1:0]           w_src_sum;
    logic                    w_last;
    logic                    w_out_free;

    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic [CH_W-1:0]         w_wdata;
    logic                    w_re;
    logic [AW-1:0]           w_raddr;
    logic [CH_W-1:0]         w_rdata;

    // Input latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode  <= t_mode'(i_mode);
            r_col   <= i_col;
            r_row   <= i_row;
            r_char  <= i_char_in;
            r_srows <= i_scroll_rows;
            r_scols <= i_scroll_cols;
        end
    end

    // Fill character register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_char <= '0;
        end else if (i_cfg_we) begin
            r_clear_char <= i_cfg_data;
        end
    end

    // Address decode for single-cell operations and scroll offset setup.
    assign w_in_range  = ({1'b0, r_col} < 9'(COLS)) && ({1'b0, r_row} < 9'(ROWS));
    assign w_cell_addr = AW'(r_row) * AW'(COLS) + AW'(r_col);
    assign w_dofs      = DW'(r_srows) * $signed(DW'(COLS)) + DW'(r_scols);
    // Sweep so that a source cell is always read before it is overwritten.
    assign w_desc      = (r_srows < 0) || ((r_srows == 0) && (r_scols < 0));

    // Source cell of the current destination during a scroll.
    assign w_src_ok  = (r_sr >= 0) && (r_sr < SP_W'(ROWS)) &&
                       (r_sc >= 0) && (r_sc < SP_W'(COLS));
    assign w_src_sum = DW'(r_addr) + r_dofs;
    assign w_last    = r_desc ? (r_addr == '0) : (r_addr == AW'(CELLS - 1));

    // Sweep counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_in_range <= w_in_range;
            r_dofs     <= w_dofs;
            if ((r_mode == MODE_SCROLL) && w_desc) begin
                r_desc <= 1'b1;
                r_addr <= AW'(CELLS - 1);
                r_c    <= CW'(COLS - 1);
                r_sc   <= SP_W'(r_scols) + SP_W'(COLS - 1);
                r_sr   <= SP_W'(r_srows) + SP_W'(ROWS - 1);
            end else begin
                r_desc <= 1'b0;
                r_addr <= '0;
                r_c    <= '0;
                r_sc   <= SP_W'(r_scols);
                r_sr   <= SP_W'(r_srows);
            end
        end else if (i_cmd.clear_step || i_cmd.scroll_step) begin
            if (r_desc) begin
                r_addr <= r_addr - 1'b1;
                if (r_c == '0) begin
                    r_c  <= CW'(COLS - 1);
                    r_sc <= SP_W'(r_scols) + SP_W'(COLS - 1);
                    r_sr <= r_sr - 1'b1;
                end else begin
                    r_c  <= r_c - 1'b1;
                    r_sc <= r_sc - 1'b1;
                end
            end else begin
                r_addr <= r_addr + 1'b1;
                if (r_c == CW'(COLS - 1)) begin
                    r_c  <= '0;
                    r_sc <= SP_W'(r_scols);
                    r_sr <= r_sr + 1'b1;
                end else begin
                    r_c  <= r_c + 1'b1;
                    r_sc <= r_sc + 1'b1;
                end
            end
        end
    end

    // Pending scroll write: the destination is held in a register until its source has been read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.scroll_step) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.exec || i_cmd.drain) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scroll_step) begin
            r_pend_addr <= r_addr;
            r_pend_ram  <= w_src_ok;
        end
    end

    // RAM port selection.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = r_clear_char;
        w_re    = 1'b0;
        w_raddr = AW'(w_src_sum);
        if (i_cmd.exec) begin
            w_waddr = w_cell_addr;
            w_wdata = r_char;
            w_raddr = w_cell_addr;
            w_we    = (r_mode == MODE_WRITE) && w_in_range;
            w_re    = (r_mode == MODE_READ) && w_in_range;
        end else if (i_cmd.clear_step) begin
            w_we = 1'b1;
        end else if (i_cmd.scroll_step || i_cmd.drain) begin
            w_we    = r_pend_valid;
            w_waddr = r_pend_addr;
            w_wdata = r_pend_ram ? w_rdata : r_clear_char;
            w_re    = i_cmd.scroll_step && w_src_ok;
        end
    end

    tgb_ram #(
        .W     (CH_W),
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Result register.
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            case (r_mode)
                MODE_READ: begin
                    r_read_char <= r_in_range ? w_rdata : '0;
                    r_out_range <= r_in_range;
                end
                MODE_WRITE: begin
                    r_read_char <= '0;
                    r_out_range <= r_in_range;
                end
                default: begin
                    r_read_char <= '0;
                    r_out_range <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_char = r_read_char;
    assign o_in_range  = r_out_range;

    assign o_sts.mode     = r_mode;
    assign o_sts.last     = w_last;
    assign o_sts.out_free = w_out_free;

endmodule

>>> hw/rtl/text_grid_buffer_with_scroll.sv
// ----------------------------------------------------------------------------
// text_grid_buffer_with_scroll
// Character grid of COLS by ROWS cells with write, read, clear and scroll.
// ----------------------------------------------------------------------------
// The block takes one word at a time. A clear and a scroll both sweep every
// cell through the single write port of the cell RAM, one cell per cycle.
// The result register lets the next word be accepted while the previous
// result still waits on the output. The cells hold no defined value after
// reset until they are written, cleared or filled by a scroll. The fill
// character may be written only while the block is idle.
module text_grid_buffer_with_scroll #(
    parameter int COLS = tgb_pkg::COLS_DEF,
    parameter int ROWS = tgb_pkg::ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] col, [15:8] row, [23:16] char_in, [32:24] scroll_rows,
    // [41:33] scroll_cols, [47:42] zero
    input  logic [47:0] i_s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  i_s_axis_tuser,
    // Result words.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] read_char, [8] in_range, [15:9] zero
    output logic [15:0] o_m_axis_tdata,
    // Fill character write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    import tgb_pkg::*;

    t_dp_cmd         w_cmd;
    t_dp_sts         w_sts;
    logic [CH_W-1:0] w_read_char;
    logic            w_in_range;

    tgb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tgb_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_mode        (i_s_axis_tuser),
        .i_col         (i_s_axis_tdata[7:0]),
        .i_row         (i_s_axis_tdata[15:8]),
        .i_char_in     (i_s_axis_tdata[23:16]),
        .i_scroll_rows ($signed(i_s_axis_tdata[32:24])),
        .i_scroll_cols ($signed(i_s_axis_tdata[41:33])),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_read_char   (w_read_char),
        .o_in_range    (w_in_range)
    );

    // The fill character register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    // Result packing.
    assign o_m_axis_tdata = {7'd0, w_in_range, w_read_char};

`ifndef ASSERT_OFF
    // One word at a time: the input closes for the cycle after an acceptance.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready
    ) else $error("input accepted on two consecutive cycles");

    // A result that reports out of range carries no character.
    a_no_char_out_of_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[8]) |-> (o_m_axis_tdata[7:0] == 8'd0)
    ) else $error("out-of-range result carries a character");

    // A new result appears only after the input side has been closed.
    a_result_after_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready)
    ) else $error("result appeared without an operation in progress");
`endif

endmodule
